### rtl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, constants and character helpers for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int COUNT_BITS = 32;
  localparam int NDIG       = 20;
  localparam int NDIG_W     = $clog2(NDIG + 1);
  localparam int DD_STEPS   = 64;
  localparam int DD_CNT_W   = $clog2(DD_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    CMD_DEC  = 3'd0,
    CMD_HEXL = 3'd1,
    CMD_HEXU = 3'd2,
    CMD_PTR  = 3'd3,
    CMD_RAW  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PRE_NONE  = 3'd0,
    PRE_MINUS = 3'd1,
    PRE_HEX   = 3'd2,
    PRE_NIL   = 3'd3,
    PRE_RAW   = 3'd4
  } pre_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        last;
    logic [31:0] bytes_sent;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit_pre;
    logic emit_dig;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic top_zero;
    logic cnt_one;
    logic pre_none;
    logic pre_last;
    logic has_digits;
  } dp_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h41 + {4'd0, d} - 8'd10;
    end else begin
      c = 8'h61 + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [2:0] pre_length(input pre_e kind);
    logic [2:0] n;
    case (kind)
      PRE_MINUS: n = 3'd1;
      PRE_HEX:   n = 3'd2;
      PRE_NIL:   n = 3'd5;
      PRE_RAW:   n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pre_char(input pre_e kind, input logic [2:0] idx,
                                          input logic [7:0] raw);
    logic [7:0] c;
    c = 8'h30;
    case (kind)
      PRE_MINUS: c = 8'h2d;
      PRE_HEX:   c = (idx == 3'd0) ? 8'h30 : 8'h78;
      PRE_NIL: begin
        case (idx)
          3'd0:    c = 8'h28;
          3'd1:    c = 8'h6e;
          3'd2:    c = 8'h69;
          3'd3:    c = 8'h6c;
          default: c = 8'h29;
        endcase
      end
      PRE_RAW:   c = raw;
      default:   c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

### rtl/ita_ctrl.sv
// ----------------------------------------------------------------------------
// ita_ctrl
// Sequencer: input handshake, binary to bcd conversion steps, leading zero
// skip, prefix and digit emission.
// ----------------------------------------------------------------------------
module ita_ctrl
  import ita_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_stall,
  output dp_cmd_t    dp_cmd,
  input  dp_stat_t   dp_stat
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_PRE  = 5'b01000,
    ST_DIG  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [DD_CNT_W-1:0] step, step_next;
  logic                cmd_ok;

  assign cmd_ok   = (in_cmd == CMD_DEC) || (in_cmd == CMD_HEXL) || (in_cmd == CMD_HEXU) ||
                    (in_cmd == CMD_PTR) || (in_cmd == CMD_RAW);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    dp_cmd     = '0;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid && cmd_ok) begin
          dp_cmd.load = 1'b1;
          state_next  = (in_cmd == CMD_DEC) ? ST_CONV : ST_SKIP;
        end
      end
      ST_CONV: begin
        dp_cmd.conv_step = 1'b1;
        step_next        = step + 1'b1;
        if (step == DD_CNT_W'(DD_STEPS - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (dp_stat.top_zero && !dp_stat.cnt_one) begin
          dp_cmd.skip_step = 1'b1;
        end else begin
          state_next = dp_stat.pre_none ? ST_DIG : ST_PRE;
        end
      end
      ST_PRE: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit_pre = 1'b1;
          if (dp_stat.pre_last) begin
            state_next = dp_stat.has_digits ? ST_DIG : ST_IDLE;
          end
        end
      end
      ST_DIG: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit_dig = 1'b1;
          if (dp_stat.cnt_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

### rtl/ita_dp.sv
// ----------------------------------------------------------------------------
// ita_dp
// Datapath: digit register with shift-add-3 conversion, prefix selection,
// output register and saturating character count.
// ----------------------------------------------------------------------------
module ita_dp
  import ita_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  dp_cmd_t   dp_cmd,
  output dp_stat_t  dp_stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [4*NDIG-1:0]   digits;
  logic [4*NDIG-1:0]   digits_adj;
  logic [63:0]         bin;
  logic [NDIG_W-1:0]   cnt;
  pre_e                pre_kind;
  logic [2:0]          pre_idx;
  logic [7:0]          raw;
  logic                upper;
  logic                has_digits;
  logic [COUNT_BITS-1:0] emit_count, emit_count_next;
  logic [63:0]         neg_value;
  logic                emit;
  logic [7:0]          emit_char;
  logic                emit_last;

  // add 3 to every bcd digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      digits_adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? digits[4*i +: 4] + 4'd3
                                                         : digits[4*i +: 4];
    end
  end

  assign neg_value = 64'd0 - in_data.value;

  assign dp_stat.out_free   = !out_valid || !out_stall;
  assign dp_stat.top_zero   = (digits[4*NDIG-1 -: 4] == 4'd0);
  assign dp_stat.cnt_one    = (cnt == NDIG_W'(1));
  assign dp_stat.pre_none   = (pre_kind == PRE_NONE);
  assign dp_stat.pre_last   = (pre_idx == pre_length(pre_kind) - 3'd1);
  assign dp_stat.has_digits = has_digits;

  assign emit      = dp_cmd.emit_pre || dp_cmd.emit_dig;
  assign emit_char = dp_cmd.emit_pre ? pre_char(pre_kind, pre_idx, raw)
                                     : digit_char(digits[4*NDIG-1 -: 4], upper);
  assign emit_last = dp_cmd.emit_pre ? (dp_stat.pre_last && !has_digits) : dp_stat.cnt_one;
  assign emit_count_next = (emit_count == COUNT_MAX) ? emit_count : emit_count + 1'b1;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      pre_idx <= '0;
      upper   <= 1'b0;
      case (in_data.cmd)
        CMD_DEC: begin
          bin        <= in_data.value[63] ? neg_value : in_data.value;
          digits     <= '0;
          cnt        <= NDIG_W'(NDIG);
          pre_kind   <= in_data.value[63] ? PRE_MINUS : PRE_NONE;
          has_digits <= 1'b1;
        end
        CMD_HEXL, CMD_HEXU: begin
          digits     <= {(4*NDIG-32)'(0), in_data.value[31:0]};
          cnt        <= NDIG_W'(NDIG);
          pre_kind   <= PRE_NONE;
          has_digits <= 1'b1;
          upper      <= (in_data.cmd == CMD_HEXU);
        end
        CMD_PTR: begin
          digits <= {(4*NDIG-64)'(0), in_data.value};
          if (in_data.value == 64'd0) begin
            cnt        <= NDIG_W'(1);
            pre_kind   <= PRE_NIL;
            has_digits <= 1'b0;
          end else begin
            cnt        <= NDIG_W'(NDIG);
            pre_kind   <= PRE_HEX;
            has_digits <= 1'b1;
          end
        end
        CMD_RAW: begin
          digits     <= '0;
          raw        <= in_data.value[7:0];
          cnt        <= NDIG_W'(1);
          pre_kind   <= PRE_RAW;
          has_digits <= 1'b0;
        end
        default: pre_kind <= PRE_NONE;
      endcase
    end else if (dp_cmd.conv_step) begin
      digits <= {digits_adj[4*NDIG-2:0], bin[63]};
      bin    <= {bin[62:0], 1'b0};
    end else if (dp_cmd.skip_step || dp_cmd.emit_dig) begin
      digits <= {digits[4*NDIG-5:0], 4'd0};
      cnt    <= cnt - 1'b1;
    end else if (dp_cmd.emit_pre) begin
      pre_idx <= pre_idx + 3'd1;
    end
  end

  // output register, parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      emit_count <= '0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        emit_count <= emit_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.char_out   <= emit_char;
      out_data.last       <= emit_last;
      out_data.bytes_sent <= 32'(emit_count_next);
    end
  end

endmodule

### rtl/integer_to_ascii_formatter.sv
// sequence: a decimal item runs the conversion steps and the leading zero skip before its
//   first character is registered; the other commands go straight to the leading zero skip
// throughput: one item at a time; the next item waits until the last character of the
//   current one is emitted, output stalls hold it, and unused codes are taken and dropped
// reset: synchronous, clears the sequencer, output valid and the character count
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a signed 64-bit decimal, 32-bit hex, 64-bit pointer or raw byte as character
// text and sends one character per output item with a running saturating count.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
  import ita_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ita_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  ita_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // never write the output register while it still holds an untaken item
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.emit_pre || dp_cmd.emit_dig) |-> dp_stat.out_free)
    else $error("character emitted into a full output register");

  // a held character that is not the last means the sequencer is still busy
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> in_stall)
    else $error("sequencer idle in the middle of an item");

  // a valid command always produces work
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.cmd == CMD_DEC || in_data.cmd == CMD_HEXL ||
     in_data.cmd == CMD_HEXU || in_data.cmd == CMD_PTR || in_data.cmd == CMD_RAW))
    |=> in_stall)
    else $error("accepted item did not start the sequencer");

endmodule
